>>> src/vna_pkg.sv
package vna_pkg;

  localparam int unsigned VERTEX_COUNT_DEF = 1024;

  // Field widths.
  localparam int unsigned KIND_W = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned NRM_W  = 16;

  // Datapath widths.
  localparam int unsigned EDGE_W  = POS_W + 1;
  localparam int unsigned CROSS_W = 51;
  localparam int unsigned MAG_W   = CROSS_W;
  localparam int unsigned OPND_W  = 31;
  localparam int unsigned PROD_W  = 2 * OPND_W;
  localparam int unsigned SQ_W    = 62;
  localparam int unsigned ROOT_W  = 31;
  localparam int unsigned REM_W   = 35;
  localparam int unsigned QUO_W   = 15;
  localparam int unsigned NUM_W   = 45;
  localparam int unsigned DREM_W  = 31;
  localparam int unsigned NORM_MAG_W = 30;
  localparam int unsigned STEP_W  = 5;

  // Last step of each multi-cycle phase.
  localparam logic [STEP_W-1:0] CORNER_LAST = 5'd2;
  localparam logic [STEP_W-1:0] CROSS_LAST  = 5'd6;
  localparam logic [STEP_W-1:0] NORM_LAST   = 5'd4;
  localparam logic [STEP_W-1:0] SQ_LAST     = 5'd3;
  localparam logic [STEP_W-1:0] SQRT_LAST   = 5'd30;
  localparam logic [STEP_W-1:0] DIV_LAST    = 5'd14;

  typedef enum logic [KIND_W-1:0] {
    KIND_VERTEX = 2'd0,
    KIND_FACE   = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  // Select codes: the vertex read address and the load source.
  localparam logic [1:0] SEL_VERTEX = 2'd3;
  localparam logic [1:0] SRC_CROSS  = 2'd0;
  localparam logic [1:0] SRC_SUM    = 2'd1;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_CLEAR   = 4'd1,
    OP_CAPTURE = 4'd2,
    OP_VWRITE  = 4'd3,
    OP_RDPOS   = 4'd4,
    OP_EDGE    = 4'd5,
    OP_CROSS   = 4'd6,
    OP_LOADV   = 4'd7,
    OP_RDSUM   = 4'd8,
    OP_NORM    = 4'd9,
    OP_SQ      = 4'd10,
    OP_SQRT    = 4'd11,
    OP_DIVINIT = 4'd12,
    OP_DIV     = 4'd13,
    OP_WRSUM   = 4'd14,
    OP_OUT     = 4'd15
  } dp_op_e;

  typedef struct packed {
    dp_op_e            op;
    logic [1:0]        sel;
    logic [STEP_W-1:0] step;
    logic              degen;
  } dp_cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic [KIND_W-1:0] kind;
    logic              idx_bad;
    logic              vec_zero;
  } dp_stat_t;

endpackage

>>> src/vna_if.sv
interface vna_in_if;
  logic                              valid;
  logic                              ready;
  logic [vna_pkg::KIND_W-1:0]        kind;
  logic [vna_pkg::IDX_W-1:0]         vertex_index;
  logic signed [vna_pkg::POS_W-1:0]  pos_x;
  logic signed [vna_pkg::POS_W-1:0]  pos_y;
  logic signed [vna_pkg::POS_W-1:0]  pos_z;
  logic [vna_pkg::IDX_W-1:0]         corner_a;
  logic [vna_pkg::IDX_W-1:0]         corner_b;
  logic [vna_pkg::IDX_W-1:0]         corner_c;

  modport source (
    output valid, kind, vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
    input  ready
  );
  modport sink (
    input  valid, kind, vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
    output ready
  );
endinterface

interface vna_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vna_pkg::NRM_W-1:0]  normal_x;
  logic signed [vna_pkg::NRM_W-1:0]  normal_y;
  logic signed [vna_pkg::NRM_W-1:0]  normal_z;
  logic                              degenerate;

  modport source (
    output valid, normal_x, normal_y, normal_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, degenerate,
    output ready
  );
endinterface

>>> src/vna_dp.sv
module vna_dp #(
  parameter int unsigned VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vna_pkg::dp_cmd_t                 cmd_i,
  output vna_pkg::dp_stat_t                stat_o,
  input  logic [vna_pkg::KIND_W-1:0]       kind_i,
  input  logic [vna_pkg::IDX_W-1:0]        vertex_index_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [vna_pkg::POS_W-1:0] pos_z_i,
  input  logic [vna_pkg::IDX_W-1:0]        corner_a_i,
  input  logic [vna_pkg::IDX_W-1:0]        corner_b_i,
  input  logic [vna_pkg::IDX_W-1:0]        corner_c_i,
  output logic signed [vna_pkg::NRM_W-1:0] normal_x_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_y_o,
  output logic signed [vna_pkg::NRM_W-1:0] normal_z_o,
  output logic                             degenerate_o
);

  localparam int unsigned AW     = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int unsigned POS_W  = vna_pkg::POS_W;
  localparam int unsigned SUM_W  = vna_pkg::SUM_W;
  localparam int unsigned ACC_W  = SUM_W + 1;
  localparam int unsigned EDGE_W = vna_pkg::EDGE_W;
  localparam int unsigned MAG_W  = vna_pkg::MAG_W;
  localparam int unsigned CROSS_W = vna_pkg::CROSS_W;
  localparam int unsigned OPND_W = vna_pkg::OPND_W;
  localparam int unsigned QUO_W  = vna_pkg::QUO_W;
  localparam int unsigned NUM_W  = vna_pkg::NUM_W;
  localparam int unsigned DREM_W = vna_pkg::DREM_W;
  localparam int unsigned REM_W  = vna_pkg::REM_W;
  localparam int unsigned SQ_W   = vna_pkg::SQ_W;
  localparam int unsigned ROOT_W = vna_pkg::ROOT_W;
  localparam int unsigned NRM_W  = vna_pkg::NRM_W;
  localparam int unsigned NMW    = vna_pkg::NORM_MAG_W;

  localparam logic [MAG_W-1:0] NORM_HI = MAG_W'(1) << 30;
  localparam logic [MAG_W-1:0] NORM_LO = MAG_W'(1) << 29;

  // Captured item.
  logic [vna_pkg::KIND_W-1:0] kind_q;
  logic [vna_pkg::IDX_W-1:0]  vi_q, ca_q, cb_q, cc_q;
  logic signed [POS_W-1:0]    px_q, py_q, pz_q;

  // Memories and their registered read data.
  logic [3*POS_W-1:0] pos_mem [VERTEX_COUNT];
  logic [3*SUM_W-1:0] sum_mem [VERTEX_COUNT];
  logic [3*POS_W-1:0] pos_rd_q, pa_q, pb_q;
  logic [3*SUM_W-1:0] sum_rd_q;
  logic [AW-1:0]      rd_addr, sum_waddr, clr_addr_q;
  logic               sum_we;
  logic [3*SUM_W-1:0] sum_wdata;

  // Arithmetic state.
  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [CROSS_W-1:0] cr_q [3];
  logic signed [OPND_W-1:0]  mul_a, mul_b;
  logic signed [2*OPND_W-1:0] prod_q;
  logic [MAG_W-1:0]          mag_q [3];
  logic                      neg_q [3];
  logic [MAG_W-1:0]          m_q;
  logic [SQ_W-1:0]           sumsq_q;
  logic [REM_W-1:0]          r_q;
  logic [ROOT_W-1:0]         q_q;
  logic [DREM_W-1:0]         rem_q [3];
  logic [QUO_W-1:0]          lo_q [3];

  // Combinational helpers.
  logic [vna_pkg::STEP_W-1:0] sm1;
  logic [1:0]                 ci;
  logic signed [CROSS_W-1:0]  src_v [3];
  logic [MAG_W-1:0]           ld_mag [3];
  logic [MAG_W-1:0]           ld_m;
  logic [4:0]                 nsh;
  logic                       go_right, go_left;
  logic [REM_W-1:0]           r_in, r2, rt;
  logic [ROOT_W-1:0]          q_in;
  logic [NUM_W-1:0]           num [3];
  logic [DREM_W:0]            rem2 [3];
  logic [DREM_W:0]            dsr;
  logic signed [NRM_W-1:0]    nmag [3];
  logic signed [NRM_W-1:0]    nrm [3];
  logic signed [ACC_W-1:0]    acc [3];
  logic [SUM_W-1:0]           sat [3];

  function automatic logic in_range(logic [vna_pkg::IDX_W-1:0] idx);
    return 32'(idx) < VERTEX_COUNT;
  endfunction

  function automatic logic signed [POS_W-1:0] comp(logic [3*POS_W-1:0] v, int i);
    return v[POS_W*(2-i) +: POS_W];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vna_pkg::OP_CAPTURE) begin
      kind_q <= kind_i;
      vi_q   <= vertex_index_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      pz_q   <= pos_z_i;
      ca_q   <= corner_a_i;
      cb_q   <= corner_b_i;
      cc_q   <= corner_c_i;
    end
  end

  always_comb begin
    stat_o.clr_done = (clr_addr_q == AW'(VERTEX_COUNT - 1));
    stat_o.kind     = kind_q;
    if (kind_q == vna_pkg::KIND_FACE) begin
      stat_o.idx_bad = !(in_range(ca_q) && in_range(cb_q) && in_range(cc_q));
    end else begin
      stat_o.idx_bad = !in_range(vi_q);
    end
    stat_o.vec_zero = (m_q == '0);
  end

  always_comb begin
    case (cmd_i.sel)
      2'd0:    rd_addr = AW'(ca_q);
      2'd1:    rd_addr = AW'(cb_q);
      2'd2:    rd_addr = AW'(cc_q);
      default: rd_addr = AW'(vi_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.op == vna_pkg::OP_CLEAR && !stat_o.clr_done) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vna_pkg::OP_VWRITE) begin
      pos_mem[AW'(vi_q)] <= {px_q, py_q, pz_q};
    end
    pos_rd_q <= pos_mem[rd_addr];
  end

  always_comb begin
    sum_we = (cmd_i.op == vna_pkg::OP_CLEAR) || (cmd_i.op == vna_pkg::OP_VWRITE) ||
             (cmd_i.op == vna_pkg::OP_WRSUM);
    if (cmd_i.op == vna_pkg::OP_CLEAR) begin
      sum_waddr = clr_addr_q;
    end else if (cmd_i.op == vna_pkg::OP_VWRITE) begin
      sum_waddr = AW'(vi_q);
    end else begin
      sum_waddr = rd_addr;
    end
    sum_wdata = (cmd_i.op == vna_pkg::OP_WRSUM) ? {sat[0], sat[1], sat[2]} : '0;
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rd_q <= sum_mem[rd_addr];
  end

  // Corner reads are issued one per cycle; each word is picked up in the cycle after its read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vna_pkg::OP_RDPOS) begin
      if (cmd_i.sel == 2'd1) begin
        pa_q <= pos_rd_q;
      end
      if (cmd_i.sel == 2'd2) begin
        pb_q <= pos_rd_q;
      end
    end
    if (cmd_i.op == vna_pkg::OP_EDGE) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= EDGE_W'(comp(pb_q, i)) - EDGE_W'(comp(pa_q, i));
        e2_q[i] <= EDGE_W'(comp(pos_rd_q, i)) - EDGE_W'(comp(pa_q, i));
      end
    end
  end

  // Shared multiplier: six cross-product terms, then three squares.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == vna_pkg::OP_CROSS) begin
      case (cmd_i.step)
        5'd0: begin mul_a = OPND_W'(e1_q[1]); mul_b = OPND_W'(e2_q[2]); end
        5'd1: begin mul_a = OPND_W'(e1_q[2]); mul_b = OPND_W'(e2_q[1]); end
        5'd2: begin mul_a = OPND_W'(e1_q[2]); mul_b = OPND_W'(e2_q[0]); end
        5'd3: begin mul_a = OPND_W'(e1_q[0]); mul_b = OPND_W'(e2_q[2]); end
        5'd4: begin mul_a = OPND_W'(e1_q[0]); mul_b = OPND_W'(e2_q[1]); end
        5'd5: begin mul_a = OPND_W'(e1_q[1]); mul_b = OPND_W'(e2_q[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (cmd_i.op == vna_pkg::OP_SQ && cmd_i.step < 5'd3) begin
      mul_a = signed'({1'b0, mag_q[cmd_i.step[1:0]][NMW-1:0]});
      mul_b = mul_a;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  assign sm1 = cmd_i.step - 1'b1;
  assign ci  = sm1[2:1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vna_pkg::OP_CROSS && cmd_i.step != '0) begin
      if (!sm1[0]) begin
        cr_q[ci] <= CROSS_W'(prod_q);
      end else begin
        cr_q[ci] <= cr_q[ci] - CROSS_W'(prod_q);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.sel == vna_pkg::SRC_CROSS) begin
        src_v[i] = cr_q[i];
      end else begin
        src_v[i] = CROSS_W'(comp(sum_rd_q, i));
      end
      ld_mag[i] = src_v[i][CROSS_W-1] ? MAG_W'(-src_v[i]) : MAG_W'(src_v[i]);
    end
    ld_m = ld_mag[0];
    if (ld_mag[1] > ld_m) ld_m = ld_mag[1];
    if (ld_mag[2] > ld_m) ld_m = ld_mag[2];
  end

  // Normalization walks shift amounts 16, 8, 4, 2, 1, one per cycle.
  always_comb begin
    nsh      = 5'(5'd16 >> cmd_i.step);
    go_right = (m_q >= NORM_HI) && ((m_q >> nsh) >= NORM_LO);
    go_left  = (m_q < NORM_LO) && ((m_q << nsh) < NORM_HI);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vna_pkg::OP_LOADV) begin
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= ld_mag[i];
        neg_q[i] <= src_v[i][CROSS_W-1];
      end
      m_q <= ld_m;
    end else if (cmd_i.op == vna_pkg::OP_NORM) begin
      if (go_right) begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> nsh;
        m_q <= m_q >> nsh;
      end else if (go_left) begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << nsh;
        m_q <= m_q << nsh;
      end
    end
  end

  // Square root: one result bit per cycle from the top pair of the radicand.
  always_comb begin
    r_in = (cmd_i.step == '0) ? '0 : r_q;
    q_in = (cmd_i.step == '0) ? '0 : q_q;
    r2   = {r_in[REM_W-3:0], sumsq_q[SQ_W-1 -: 2]};
    rt   = REM_W'({q_in, 2'b01});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vna_pkg::OP_SQ) begin
      if (cmd_i.step == 5'd1) begin
        sumsq_q <= SQ_W'(unsigned'(prod_q));
      end else if (cmd_i.step != '0) begin
        sumsq_q <= sumsq_q + SQ_W'(unsigned'(prod_q));
      end
    end else if (cmd_i.op == vna_pkg::OP_SQRT) begin
      sumsq_q <= sumsq_q << 2;
      if (r2 >= rt) begin
        r_q <= r2 - rt;
        q_q <= {q_in[ROOT_W-2:0], 1'b1};
      end else begin
        r_q <= r2;
        q_q <= {q_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Three restoring dividers; the quotient bits shift in as dividend bits shift out.
  always_comb begin
    dsr = {1'b0, q_q};
    for (int k = 0; k < 3; k++) begin
      num[k]  = (NUM_W'(mag_q[k][NMW-1:0]) << 14) + NUM_W'(q_q >> 1);
      rem2[k] = {rem_q[k], lo_q[k][QUO_W-1]};
      nmag[k] = signed'(NRM_W'(lo_q[k]));
      nrm[k]  = neg_q[k] ? -nmag[k] : nmag[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.op == vna_pkg::OP_DIVINIT) begin
        rem_q[k] <= DREM_W'(num[k][NUM_W-1:QUO_W]);
        lo_q[k]  <= num[k][QUO_W-1:0];
      end else if (cmd_i.op == vna_pkg::OP_DIV) begin
        if (rem2[k] >= dsr) begin
          rem_q[k] <= DREM_W'(rem2[k] - dsr);
          lo_q[k]  <= {lo_q[k][QUO_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= rem2[k][DREM_W-1:0];
          lo_q[k]  <= {lo_q[k][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(comp(sum_rd_q, i)) + ACC_W'(nrm[i]);
      if (acc[i][ACC_W-1] != acc[i][ACC_W-2]) begin
        sat[i] = acc[i][ACC_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sat[i] = acc[i][SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vna_pkg::OP_OUT) begin
      normal_x_o   <= cmd_i.degen ? '0 : nrm[0];
      normal_y_o   <= cmd_i.degen ? '0 : nrm[1];
      normal_z_o   <= cmd_i.degen ? '0 : nrm[2];
      degenerate_o <= cmd_i.degen;
    end
  end

endmodule

>>> src/vna_ctrl.sv
module vna_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  vna_pkg::dp_stat_t stat_i,
  output vna_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [15:0] {
    S_CLEAR  = 16'h0001,
    S_IDLE   = 16'h0002,
    S_DECODE = 16'h0004,
    S_RDPOS  = 16'h0008,
    S_EDGE   = 16'h0010,
    S_CROSS  = 16'h0020,
    S_LOADV  = 16'h0040,
    S_QRD    = 16'h0080,
    S_NORM   = 16'h0100,
    S_SQ     = 16'h0200,
    S_SQRT   = 16'h0400,
    S_DIVI   = 16'h0800,
    S_DIV    = 16'h1000,
    S_SRD    = 16'h2000,
    S_SWR    = 16'h4000,
    S_OUT    = 16'h8000
  } state_e;

  state_e                          state_q, state_d;
  logic [vna_pkg::STEP_W-1:0]      step_q, step_d;
  logic                            degen_q, degen_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_set;
  logic                            is_face;

  assign is_face     = (stat_i.kind == vna_pkg::KIND_FACE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    degen_d    = degen_q;
    out_set    = 1'b0;
    in_ready_o = 1'b0;
    cmd_o      = '{op: vna_pkg::OP_NONE, sel: 2'd0, step: step_q, degen: 1'b0};
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = vna_pkg::OP_CLEAR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = vna_pkg::OP_CAPTURE;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        step_d  = '0;
        state_d = S_IDLE;
        unique case (stat_i.kind)
          vna_pkg::KIND_VERTEX: begin
            if (!stat_i.idx_bad) cmd_o.op = vna_pkg::OP_VWRITE;
          end
          vna_pkg::KIND_FACE: begin
            if (!stat_i.idx_bad) state_d = S_RDPOS;
          end
          vna_pkg::KIND_QUERY: begin
            if (stat_i.idx_bad) begin
              degen_d = 1'b1;
              state_d = S_OUT;
            end else begin
              state_d = S_QRD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RDPOS: begin
        cmd_o.op  = vna_pkg::OP_RDPOS;
        cmd_o.sel = step_q[1:0];
        if (step_q == vna_pkg::CORNER_LAST) begin
          state_d = S_EDGE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_EDGE: begin
        cmd_o.op = vna_pkg::OP_EDGE;
        step_d   = '0;
        state_d  = S_CROSS;
      end
      S_CROSS: begin
        cmd_o.op = vna_pkg::OP_CROSS;
        if (step_q == vna_pkg::CROSS_LAST) begin
          state_d = S_LOADV;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_QRD: begin
        cmd_o.op  = vna_pkg::OP_RDSUM;
        cmd_o.sel = vna_pkg::SEL_VERTEX;
        state_d   = S_LOADV;
      end
      S_LOADV: begin
        cmd_o.op  = vna_pkg::OP_LOADV;
        cmd_o.sel = is_face ? vna_pkg::SRC_CROSS : vna_pkg::SRC_SUM;
        step_d    = '0;
        state_d   = S_NORM;
      end
      S_NORM: begin
        if (stat_i.vec_zero) begin
          // A zero vector: a face adds nothing, a query reports degenerate.
          if (is_face) begin
            state_d = S_IDLE;
          end else begin
            degen_d = 1'b1;
            state_d = S_OUT;
          end
        end else begin
          cmd_o.op = vna_pkg::OP_NORM;
          if (step_q == vna_pkg::NORM_LAST) begin
            step_d  = '0;
            state_d = S_SQ;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      S_SQ: begin
        cmd_o.op = vna_pkg::OP_SQ;
        if (step_q == vna_pkg::SQ_LAST) begin
          step_d  = '0;
          state_d = S_SQRT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.op = vna_pkg::OP_SQRT;
        if (step_q == vna_pkg::SQRT_LAST) begin
          state_d = S_DIVI;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DIVI: begin
        cmd_o.op = vna_pkg::OP_DIVINIT;
        step_d   = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = vna_pkg::OP_DIV;
        if (step_q == vna_pkg::DIV_LAST) begin
          step_d  = '0;
          degen_d = 1'b0;
          state_d = is_face ? S_SRD : S_OUT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_SRD: begin
        cmd_o.op  = vna_pkg::OP_RDSUM;
        cmd_o.sel = step_q[1:0];
        state_d   = S_SWR;
      end
      S_SWR: begin
        cmd_o.op  = vna_pkg::OP_WRSUM;
        cmd_o.sel = step_q[1:0];
        if (step_q == vna_pkg::CORNER_LAST) begin
          state_d = S_IDLE;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = vna_pkg::OP_OUT;
          cmd_o.degen = degen_q;
          out_set     = 1'b1;
          degen_d     = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_set) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= '0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      degen_q     <= degen_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DECODE)
    else $error("accepted word not followed by decode");

  a_out_reg_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == vna_pkg::OP_OUT |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still held");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output state");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !out_valid_q)
    else $error("result pending during clearing pass");
`endif

endmodule

>>> src/vertex_normal_accumulator_core.sv
// A vertex word is stored at decode; a query result becomes valid, and a face finishes, after the
// square root and divide steps, which a zero cross product or a degenerate query skips.
// The bit-serial square root and the bit-serial dividers dominate.
// Throughput: one word at a time; the next word is accepted in the cycle after the previous one
// finishes, and a query waits while the previous result is still held in the output register.
// Reset: asynchronous and active low; afterwards the normal-sum memory is cleared in a
// pass over all VERTEX_COUNT entries, during which no input word is accepted.
module vertex_normal_accumulator_core #(
  parameter int unsigned VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vna_in_if.sink     in_i,
  vna_out_if.source  out_o
);

  vna_pkg::dp_cmd_t  cmd;
  vna_pkg::dp_stat_t stat;

  vna_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  vna_dp #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (in_i.kind),
    .vertex_index_i (in_i.vertex_index),
    .pos_x_i        (in_i.pos_x),
    .pos_y_i        (in_i.pos_y),
    .pos_z_i        (in_i.pos_z),
    .corner_a_i     (in_i.corner_a),
    .corner_b_i     (in_i.corner_b),
    .corner_c_i     (in_i.corner_c),
    .normal_x_o     (out_o.normal_x),
    .normal_y_o     (out_o.normal_y),
    .normal_z_o     (out_o.normal_z),
    .degenerate_o   (out_o.degenerate)
  );

endmodule

>>> tb/tb_vertex_normal_accumulator_core.sv
module tb_vertex_normal_accumulator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VCOUNT = vna_pkg::VERTEX_COUNT_DEF;
  localparam int unsigned KIND_W = vna_pkg::KIND_W;
  localparam int unsigned IDX_W  = vna_pkg::IDX_W;
  localparam int unsigned POS_W  = vna_pkg::POS_W;
  localparam int unsigned NRM_W  = vna_pkg::NRM_W;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned N_WORDS = 1250;
  localparam int LONG_HOLD = 3000;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         vertex_index;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [IDX_W-1:0]         corner_a;
    logic [IDX_W-1:0]         corner_b;
    logic [IDX_W-1:0]         corner_c;
  } word_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    degenerate;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vna_in_if  in_bus ();
  vna_out_if out_bus ();

  vertex_normal_accumulator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state.
  longint pos_mem [VCOUNT][3];
  longint sum_mem [VCOUNT][3];
  bit     written [VCOUNT];

  word_t   pending_words [$];
  normal_t expected_normals [$];
  int      fail_count = 0;
  int      added_count = 0;
  bit      hold_sender = 0;
  bit      long_stall = 0;
  bit      sent_drained = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // Scales a vector to a Q1.14 unit vector; returns 0 for a zero vector.
  function automatic bit to_unit(input longint v [3], output longint u [3]);
    longint unsigned mag [3];
    bit neg [3];
    longint unsigned m, sq, len, c;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      m <<= 1;
    end
    sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      c = (mag[i] * 16384 + len / 2) / len;
      u[i] = neg[i] ? -longint'(c) : longint'(c);
    end
    return 1;
  endfunction

  function automatic longint clamp_sum(longint s);
    if (s > 8388607) return 8388607;
    if (s < -8388608) return -8388608;
    return s;
  endfunction

  task automatic predict_word(input word_t w);
    longint e1 [3], e2 [3], cr [3], u [3], sv [3];
    int idx [3];
    normal_t r;
    bit ok;
    case (w.kind)
      vna_pkg::KIND_VERTEX: begin
        if (w.vertex_index < VCOUNT) begin
          pos_mem[w.vertex_index][0] = w.pos_x;
          pos_mem[w.vertex_index][1] = w.pos_y;
          pos_mem[w.vertex_index][2] = w.pos_z;
          for (int i = 0; i < 3; i++) sum_mem[w.vertex_index][i] = 0;
        end
      end
      vna_pkg::KIND_FACE: begin
        idx[0] = w.corner_a;
        idx[1] = w.corner_b;
        idx[2] = w.corner_c;
        if (idx[0] < VCOUNT && idx[1] < VCOUNT && idx[2] < VCOUNT) begin
          for (int i = 0; i < 3; i++) begin
            e1[i] = pos_mem[idx[1]][i] - pos_mem[idx[0]][i];
            e2[i] = pos_mem[idx[2]][i] - pos_mem[idx[0]][i];
          end
          cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
          cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
          cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
          if (to_unit(cr, u))
            for (int k = 0; k < 3; k++)
              for (int i = 0; i < 3; i++)
                sum_mem[idx[k]][i] = clamp_sum(sum_mem[idx[k]][i] + u[i]);
        end
      end
      vna_pkg::KIND_QUERY: begin
        ok = 0;
        for (int i = 0; i < 3; i++) u[i] = 0;
        if (w.vertex_index < VCOUNT) begin
          for (int i = 0; i < 3; i++) sv[i] = sum_mem[w.vertex_index][i];
          ok = to_unit(sv, u);
        end
        r.nx = NRM_W'(u[0]);
        r.ny = NRM_W'(u[1]);
        r.nz = NRM_W'(u[2]);
        r.degenerate = !ok;
        expected_normals = {expected_normals, r};
      end
      default: ;
    endcase
  endtask

  // Stimulus helpers; live_idx lists the written vertex slots that pick_live draws on.
  int live_idx [$];

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return POS_W'($urandom_range(0, 4095) - 2048);
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic word_t rand_word();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return word_t'(r[$bits(word_t)-1:0]);
  endfunction

  function automatic word_t vertex_word(int idx);
    word_t w;
    w = rand_word();
    w.kind = vna_pkg::KIND_VERTEX;
    w.vertex_index = IDX_W'(idx);
    w.pos_x = rand_pos();
    w.pos_y = rand_pos();
    w.pos_z = rand_pos();
    return w;
  endfunction

  function automatic word_t face_word(int a, int b, int c);
    word_t w;
    w = rand_word();
    w.kind = vna_pkg::KIND_FACE;
    w.corner_a = IDX_W'(a);
    w.corner_b = IDX_W'(b);
    w.corner_c = IDX_W'(c);
    return w;
  endfunction

  function automatic word_t query_word(int idx);
    word_t w;
    w = rand_word();
    w.kind = vna_pkg::KIND_QUERY;
    w.vertex_index = IDX_W'(idx);
    return w;
  endfunction

  task automatic add_word(word_t w);
    if (w.kind == vna_pkg::KIND_VERTEX && !written[w.vertex_index]) begin
      written[w.vertex_index] = 1;
      live_idx = {live_idx, int'(w.vertex_index)};
    end
    pending_words = {pending_words, w};
    added_count++;
  endtask

  function automatic int pick_live();
    return live_idx[$urandom_range(0, live_idx.size() - 1)];
  endfunction

  // Driver: bursts of offered words with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  word_t cur_word;
  bit offering = 0;
  bit took_q = 0;

  always @(posedge clk_i) begin
    took_q <= rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      predict_word(cur_word);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (offering && took_q) begin
        offering = 0;
        if (burst_left > 0) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 30);
        end
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (!hold_sender && pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          offering = 1;
          {in_bus.kind, in_bus.vertex_index, in_bus.pos_x, in_bus.pos_y, in_bus.pos_z,
           in_bus.corner_a, in_bus.corner_b, in_bus.corner_c} <= cur_word;
        end
      end
      in_bus.valid <= offering;
    end
  end

  // Receiver with its own stall pattern and one long hold-off.
  int stall_phase = 0;
  int long_count = 0;

  always @(negedge clk_i) begin
    if (long_stall && long_count < LONG_HOLD) begin
      out_bus.ready <= 1'b0;
      long_count <= long_count + 1;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 200) % 3)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        default: out_bus.ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  normal_t got, want;
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles <= 0;
      else if (!long_stall)
        idle_cycles <= idle_cycles + 1;
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.normal_x, out_bus.normal_y, out_bus.normal_z, out_bus.degenerate};
        if (expected_normals.size() == 0) begin
          $error("unexpected result word %h", got);
          fail_count++;
        end else begin
          want = expected_normals.pop_front();
          if (got.nx !== want.nx) begin
            $error("normal_x exp %0d got %0d", want.nx, got.nx);
            fail_count++;
          end
          if (got.ny !== want.ny) begin
            $error("normal_y exp %0d got %0d", want.ny, got.ny);
            fail_count++;
          end
          if (got.nz !== want.nz) begin
            $error("normal_z exp %0d got %0d", want.nz, got.nz);
            fail_count++;
          end
          if (got.degenerate !== want.degenerate) begin
            $error("degenerate exp %0b got %0b", want.degenerate, got.degenerate);
            fail_count++;
          end
        end
      end
      if (idle_cycles > STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Builds a random mesh fragment: a few vertices, faces mostly over them, then queries.
  task automatic add_mesh_group();
    int base, n, a, b, c;
    n = $urandom_range(3, 6);
    base = $urandom_range(0, VCOUNT - n);
    for (int i = 0; i < n; i++) add_word(vertex_word(base + i));
    for (int i = 0; i < $urandom_range(1, 5); i++) begin
      a = base + $urandom_range(0, n - 1);
      b = base + $urandom_range(0, n - 1);
      c = ($urandom_range(0, 7) == 0) ? pick_live() : base + $urandom_range(0, n - 1);
      add_word(face_word(a, b, c));
    end
    for (int i = 0; i < $urandom_range(1, 3); i++)
      add_word(query_word(base + $urandom_range(0, n - 1)));
  endtask

  word_t w;

  initial begin
    in_bus.valid = 1'b0;
    {in_bus.kind, in_bus.vertex_index, in_bus.pos_x, in_bus.pos_y, in_bus.pos_z,
     in_bus.corner_a, in_bus.corner_b, in_bus.corner_c} = '0;
    out_bus.ready = 1'b0;
    for (int i = 0; i < VCOUNT; i++)
      for (int k = 0; k < 3; k++) begin
        pos_mem[i][k] = 0;
        sum_mem[i][k] = 0;
      end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: query before any write, extremes, a real face, degenerate faces, kind 3.
    add_word(query_word(0));
    add_word(query_word(VCOUNT - 1));
    w = vertex_word(0);
    w.pos_x = 0; w.pos_y = 0; w.pos_z = 0;
    add_word(w);
    w = vertex_word(1);
    w.pos_x = 24'sh7FFFFF; w.pos_y = 0; w.pos_z = 0;
    add_word(w);
    w = vertex_word(2);
    w.pos_x = 0; w.pos_y = 24'sh7FFFFF; w.pos_z = 0;
    add_word(w);
    w = vertex_word(3);
    w.pos_x = 24'sh800000; w.pos_y = 24'sh800000; w.pos_z = 24'sh800000;
    add_word(w);
    w = vertex_word(VCOUNT - 1);
    w.pos_x = 24'sh7FFFFF; w.pos_y = 24'sh800000; w.pos_z = 24'sh7FFFFF;
    add_word(w);
    add_word(face_word(0, 1, 2));
    add_word(query_word(0));
    add_word(face_word(0, 0, 1));
    add_word(face_word(1, 2, 2));
    add_word(face_word(3, 1, VCOUNT - 1));
    add_word(face_word(0, 1, 0));
    // Collinear corners: 0, 1 and vertex 4 on the x axis.
    w = vertex_word(4);
    w.pos_x = 24'sh001000; w.pos_y = 0; w.pos_z = 0;
    add_word(w);
    add_word(face_word(0, 1, 4));
    add_word(query_word(3));
    add_word(query_word(VCOUNT - 1));
    add_word(query_word(4));
    w = query_word(0); w.kind = 2'd3;
    add_word(w);
    // Repeated accumulation: the same face six more times.
    for (int i = 0; i < 6; i++) add_word(face_word(0, 1, 2));
    add_word(query_word(1));

    // Let the directed words go, then hold the receiver off while sending more.
    wait (pending_words.size() == 0);
    long_stall = 1;
    for (int i = 0; i < 8; i++) add_mesh_group();
    wait (long_count >= LONG_HOLD);
    long_stall = 0;

    while (added_count < N_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        w = rand_word();
        if (w.kind == vna_pkg::KIND_FACE) begin
          w.corner_a = IDX_W'(pick_live());
          w.corner_b = IDX_W'(pick_live());
          w.corner_c = IDX_W'(pick_live());
        end
        add_word(w);
      end else if ($urandom_range(0, 3) == 0) begin
        add_word(face_word(pick_live(), pick_live(), pick_live()));
        add_word(query_word(pick_live()));
      end else begin
        add_mesh_group();
      end
      if (pending_words.size() > 40) wait (pending_words.size() < 10);
      if (!sent_drained && added_count > N_WORDS / 2) begin
        // The sender pauses with words still queued until every result is back.
        sent_drained = 1;
        hold_sender = 1;
        wait (!offering && expected_normals.size() == 0);
        hold_sender = 0;
      end
    end
    wait (pending_words.size() == 0 && !offering && expected_normals.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
